// File: rtl/hdr_tm_pkg.sv
// ---------------------------------------------------------------------------
// HDR tone mapper package
// Shared types, constants and per-stage step functions of the tone mapper.
// ---------------------------------------------------------------------------
package hdr_tm_pkg;

	localparam int DEF_MAX_WIDTH  = 4096;
	localparam int DEF_MAX_HEIGHT = 4096;

	localparam logic [2:0] REG_EXPOSURE     = 3'd0;
	localparam logic [2:0] REG_CURVE_ENABLE = 3'd1;
	localparam logic [2:0] REG_CURVE_SELECT = 3'd2;
	localparam logic [2:0] REG_GAMMA        = 3'd3;
	localparam logic [2:0] REG_FRAME_WIDTH  = 3'd4;
	localparam logic [2:0] REG_FRAME_HEIGHT = 3'd5;

	localparam logic [1:0] CURVE_REINHARD = 2'd0;
	localparam logic [1:0] CURVE_ACES     = 2'd1;
	localparam logic [1:0] CURVE_FILMIC   = 2'd2;
	localparam logic [1:0] CURVE_FALLBACK = 2'd3;

	localparam logic [16:0] ONE_Q16 = 17'd65536;

	localparam logic [17:0] ACES_A   = 18'd164495;
	localparam logic [30:0] ACES_B   = 31'd1966;
	localparam logic [17:0] ACES_C   = 18'd159252;
	localparam logic [30:0] ACES_D   = 31'd38666;
	localparam logic [47:0] ACES_E   = 48'd9175;
	localparam logic [31:0] ACES_MAX = 32'h0100_0000;

	localparam logic [17:0] FILM_A   = 18'd9830;
	localparam logic [30:0] FILM_CB  = 31'd3277;
	localparam logic [30:0] FILM_B   = 31'd32768;
	localparam logic [47:0] FILM_DE  = 48'd262;
	localparam logic [47:0] FILM_DF  = 48'd3932;
	localparam logic [16:0] FILM_EF  = 17'd4369;

	localparam int DIV1_STEPS      = 32;
	localparam int CURVE_DIV_STEPS = 17;
	localparam int SQ_STEPS        = 16;
	localparam int GAM_DIV_STEPS   = 29;
	localparam int HORNER_STEPS    = 6;

	localparam int PIPE_DEPTH = 1 + DIV1_STEPS + 4 + CURVE_DIV_STEPS + 2 + SQ_STEPS + 1
		+ GAM_DIV_STEPS + 1 + HORNER_STEPS + 1;

	localparam logic [17:0] HORNER_INIT = 18'd10;
	localparam logic [17:0] HORNER_C [HORNER_STEPS] = '{
		18'd87, 18'd630, 18'd3638, 18'd15743, 18'd45426, 18'd65536
	};

	typedef struct packed {
		logic [31:0] exposure;
		logic        curve_enable;
		logic [1:0]  curve_select;
		logic [15:0] gamma;
	} tm_cfg_t;

	typedef struct packed {
		logic [23:0] rem;
		logic [31:0] q;
		logic [23:0] den;
	} div1_t;

	typedef struct packed {
		logic [47:0] rem;
		logic [16:0] q;
		logic [47:0] den;
		logic        nb;
		logic [16:0] vby;
	} div2_t;

	typedef struct packed {
		logic [16:0] m;
		logic [15:0] frac;
		logic [4:0]  p;
		logic [16:0] v;
	} sq_t;

	typedef struct packed {
		logic [15:0] rem;
		logic [28:0] q;
		logic [16:0] v;
	} div3_t;

	typedef struct packed {
		logic [17:0] acc;
		logic [16:0] x;
		logic [12:0] ei;
		logic [15:0] ef;
		logic [16:0] v;
	} hr_t;

	function automatic logic [16:0] sat_one(logic [16:0] v);
		return (v > ONE_Q16) ? ONE_Q16 : v;
	endfunction

	function automatic logic [4:0] lead_one(logic [16:0] v);
		logic [4:0] p;
		p = 5'd0;
		for (int i = 0; i < 17; i++) begin
			if (v[i]) begin
				p = 5'(i);
			end
		end
		return p;
	endfunction

	function automatic div1_t div1_step(div1_t a);
		logic [24:0] t;
		div1_t       r;
		t = {a.rem, a.q[31]};
		r = a;
		if (t >= {1'b0, a.den}) begin
			r.rem = 24'(t - {1'b0, a.den});
			r.q   = {a.q[30:0], 1'b1};
		end else begin
			r.rem = t[23:0];
			r.q   = {a.q[30:0], 1'b0};
		end
		return r;
	endfunction

	function automatic div2_t div2_step(div2_t a);
		logic [48:0] t;
		div2_t       r;
		t = {a.rem, a.nb};
		r = a;
		r.nb = 1'b0;
		if (t >= {1'b0, a.den}) begin
			r.rem = 48'(t - {1'b0, a.den});
			r.q   = {a.q[15:0], 1'b1};
		end else begin
			r.rem = t[47:0];
			r.q   = {a.q[15:0], 1'b0};
		end
		return r;
	endfunction

	function automatic sq_t sq_step(sq_t a);
		logic [33:0] sq;
		logic [17:0] s;
		sq_t         r;
		sq = a.m * a.m;
		s  = sq[33:16];
		r  = a;
		if (s[17]) begin
			r.m    = s[17:1];
			r.frac = {a.frac[14:0], 1'b1};
		end else begin
			r.m    = s[16:0];
			r.frac = {a.frac[14:0], 1'b0};
		end
		return r;
	endfunction

	function automatic div3_t div3_step(div3_t a, logic [15:0] g);
		logic [16:0] t;
		div3_t       r;
		t = {a.rem, a.q[28]};
		r = a;
		if (t >= {1'b0, g}) begin
			r.rem = 16'(t - {1'b0, g});
			r.q   = {a.q[27:0], 1'b1};
		end else begin
			r.rem = t[15:0];
			r.q   = {a.q[27:0], 1'b0};
		end
		return r;
	endfunction

	function automatic hr_t hr_step(hr_t a, logic [17:0] c);
		logic [34:0] pr;
		hr_t         r;
		pr    = a.acc * a.x;
		r     = a;
		r.acc = c + 18'(pr[34:16]);
		return r;
	endfunction

endpackage

// File: rtl/hdr_tm_intf.sv
// ---------------------------------------------------------------------------
// HDR tone mapper channels
// Accumulated pixel input, display pixel output and register write channel.
// ---------------------------------------------------------------------------
interface hdr_tm_accum_if;
	logic        valid;
	logic        ready;
	logic [31:0] accum_red;
	logic [31:0] accum_green;
	logic [31:0] accum_blue;
	logic [23:0] sample_count;
	logic [11:0] column;
	logic [11:0] row;

	modport source (output valid, accum_red, accum_green, accum_blue, sample_count,
		column, row, input ready);
	modport sink (input valid, accum_red, accum_green, accum_blue, sample_count,
		column, row, output ready);
endinterface

interface hdr_tm_disp_if;
	logic        valid;
	logic        ready;
	logic [7:0]  out_red;
	logic [7:0]  out_green;
	logic [7:0]  out_blue;
	logic [23:0] pixel_index;

	modport source (output valid, out_red, out_green, out_blue, pixel_index, input ready);
	modport sink (input valid, out_red, out_green, out_blue, pixel_index, output ready);
endinterface

interface hdr_tm_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [31:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/hdr_tm_chan.sv
// ---------------------------------------------------------------------------
// HDR tone mapper color channel
// Average, exposure, tone curve, gamma and byte conversion of one channel.
// ---------------------------------------------------------------------------
module hdr_tm_chan
	import hdr_tm_pkg::*;
(
	input  logic        clk,
	input  logic        en,
	input  tm_cfg_t     cfg,
	input  logic [31:0] sum,
	input  logic [23:0] count,
	output logic [7:0]  pix
);

	div1_t       d1_s [0:DIV1_STEPS];
	logic [63:0] prod_s33;
	logic [31:0] x_s34;
	logic [16:0] vby_s34;
	logic [31:0] xm_s35;
	logic [31:0] xr_s35;
	logic [30:0] t1_s35;
	logic [30:0] t2_s35;
	logic [16:0] vby_s35;
	div2_t       d2_s [0:CURVE_DIV_STEPS];
	logic [16:0] v_s54;
	sq_t         sq_s [0:SQ_STEPS];
	div3_t       d3_s [0:GAM_DIV_STEPS];
	hr_t         hr_s [0:HORNER_STEPS];
	logic [7:0]  pix_s109;

	logic [31:0] xc;
	logic [31:0] xm;
	logic [17:0] k1;
	logic [17:0] k2;
	logic [30:0] c1;
	logic [30:0] c2;
	logic [49:0] p1;
	logic [49:0] p2;
	logic [62:0] n1;
	logic [62:0] n2;
	logic [47:0] num;
	logic [47:0] den;
	logic [16:0] q2;
	logic [16:0] yc;
	logic [15:0] gam;
	logic [20:0] nl;
	logic [28:0] e;
	logic [16:0] res;
	logic [17:0] sh;
	logic [24:0] r255;

	assign xc  = (x_s34 > ACES_MAX) ? ACES_MAX : x_s34;
	assign gam = (cfg.gamma == 16'd0) ? 16'd1 : cfg.gamma;

	always_comb begin
		case (cfg.curve_select)
			CURVE_ACES: begin
				xm = xc;
				k1 = ACES_A;
				c1 = ACES_B;
				k2 = ACES_C;
				c2 = ACES_D;
			end
			default: begin
				xm = x_s34;
				k1 = FILM_A;
				c1 = FILM_CB;
				k2 = FILM_A;
				c2 = FILM_B;
			end
		endcase
		p1 = xm * k1;
		p2 = xm * k2;
	end

	always_comb begin
		n1 = xm_s35 * t1_s35;
		n2 = xm_s35 * t2_s35;
		case (cfg.curve_select)
			CURVE_ACES: begin
				num = 48'(n1[62:16]);
				den = 48'(n2[62:16]) + ACES_E;
			end
			CURVE_FILMIC: begin
				num = 48'(n1[62:16]) + FILM_DE;
				den = 48'(n2[62:16]) + FILM_DF;
			end
			default: begin
				num = 48'(xr_s35);
				den = 48'(xr_s35) + 48'(ONE_Q16);
			end
		endcase
	end

	always_comb begin
		q2 = d2_s[CURVE_DIV_STEPS].q;
		if (cfg.curve_select == CURVE_FILMIC) begin
			yc = (q2 > FILM_EF) ? q2 - FILM_EF : 17'd0;
		end else begin
			yc = q2;
		end
	end

	assign nl = {5'd16 - sq_s[SQ_STEPS].p, 16'd0} - {5'd0, sq_s[SQ_STEPS].frac};
	assign e  = d3_s[GAM_DIV_STEPS].q;

	always_comb begin
		sh = hr_s[HORNER_STEPS].acc >> (hr_s[HORNER_STEPS].ei + 13'd1);
		if (!cfg.curve_enable) begin
			res = hr_s[HORNER_STEPS].v;
		end else if (hr_s[HORNER_STEPS].v == 17'd0) begin
			res = 17'd0;
		end else if (hr_s[HORNER_STEPS].ei >= 13'd18) begin
			res = 17'd0;
		end else if (hr_s[HORNER_STEPS].ef == 16'd0) begin
			res = ONE_Q16 >> hr_s[HORNER_STEPS].ei;
		end else begin
			res = (sh > 18'(ONE_Q16)) ? ONE_Q16 : sh[16:0];
		end
		r255 = {res, 8'd0} - 25'(res);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d1_s[0] <= '{rem: 24'd0, q: sum, den: (count > 24'd1) ? count : 24'd1};
			for (int k = 0; k < DIV1_STEPS; k++) begin
				d1_s[k+1] <= div1_step(d1_s[k]);
			end

			prod_s33 <= d1_s[DIV1_STEPS].q * cfg.exposure;

			x_s34   <= (prod_s33[63:48] != 16'd0) ? 32'hFFFF_FFFF : prod_s33[47:16];
			vby_s34 <= (prod_s33[63:48] != 16'd0 || prod_s33[47:16] > 32'(ONE_Q16))
				? ONE_Q16 : prod_s33[32:16];

			xm_s35  <= xm;
			xr_s35  <= x_s34;
			t1_s35  <= 31'(p1[49:16]) + c1;
			t2_s35  <= 31'(p2[49:16]) + c2;
			vby_s35 <= vby_s34;

			d2_s[0] <= '{rem: {1'b0, num[47:1]}, q: 17'd0, den: den, nb: num[0],
				vby: vby_s35};
			for (int k = 0; k < CURVE_DIV_STEPS; k++) begin
				d2_s[k+1] <= div2_step(d2_s[k]);
			end

			v_s54 <= cfg.curve_enable ? sat_one(yc) : d2_s[CURVE_DIV_STEPS].vby;

			sq_s[0] <= '{m: 17'(({v_s54, 16'd0} >> lead_one(v_s54))), frac: 16'd0,
				p: lead_one(v_s54), v: v_s54};
			for (int k = 0; k < SQ_STEPS; k++) begin
				sq_s[k+1] <= sq_step(sq_s[k]);
			end

			d3_s[0] <= '{rem: 16'd0, q: {nl, 8'd0}, v: sq_s[SQ_STEPS].v};
			for (int k = 0; k < GAM_DIV_STEPS; k++) begin
				d3_s[k+1] <= div3_step(d3_s[k], gam);
			end

			hr_s[0] <= '{acc: HORNER_INIT, x: ONE_Q16 - {1'b0, e[15:0]}, ei: e[28:16],
				ef: e[15:0], v: d3_s[GAM_DIV_STEPS].v};
			for (int k = 0; k < HORNER_STEPS; k++) begin
				hr_s[k+1] <= hr_step(hr_s[k], HORNER_C[k]);
			end

			pix_s109 <= r255[23:16];
		end
	end

	assign pix = pix_s109;

endmodule

// File: rtl/hdr_tonemap_pixel.sv
// ---------------------------------------------------------------------------
// HDR pixel tone mapper
// Turns accumulated HDR pixels into display bytes and a flipped pixel index.
// ---------------------------------------------------------------------------
// The accum channel takes one accumulated pixel per transfer and the display
// channel gives one display pixel per transfer, in the same order. Registers
// are written over the cfg channel, which is always ready; the user must make
// writes only while no pixel is in flight, as the block does not enforce it.
// Every pixel passes through 110 register stages. A new pixel is taken every
// cycle while the receiver does not hold the pipeline; the depth comes from
// the bit-per-stage dividers for the sample average, the curve quotient and
// the gamma exponent, and the 16 squaring stages of the logarithm.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and accum.ready drops; nothing is lost or repeated.
// Reset empties the pipeline and loads the register reset values.
// ---------------------------------------------------------------------------
module hdr_tonemap_pixel
	import hdr_tm_pkg::*;
#(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
	input logic            clk,
	input logic            arst_n,
	hdr_tm_accum_if.sink   accum,
	hdr_tm_disp_if.source  display,
	hdr_tm_cfg_if.sink     cfg
);

	logic [31:0] exposure_q;
	logic        curve_enable_q;
	logic [1:0]  curve_select_q;
	logic [15:0] gamma_q;
	logic [12:0] width_q;
	logic [12:0] height_q;

	logic        vld_s [0:PIPE_DEPTH-1];
	logic [23:0] idx_s [0:PIPE_DEPTH-1];

	logic        en;
	tm_cfg_t     tcfg;
	logic [23:0] dy;
	logic [36:0] idx_prod;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exposure_q     <= 32'd65536;
			curve_enable_q <= 1'b1;
			curve_select_q <= CURVE_REINHARD;
			gamma_q        <= 16'd563;
			width_q        <= 13'd1024;
			height_q       <= 13'd768;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_EXPOSURE:     exposure_q     <= cfg.data;
				REG_CURVE_ENABLE: curve_enable_q <= cfg.data[0];
				REG_CURVE_SELECT: curve_select_q <= cfg.data[1:0];
				REG_GAMMA:        gamma_q        <= cfg.data[15:0];
				REG_FRAME_WIDTH: begin
					width_q <= (32'(cfg.data[12:0]) > MAX_WIDTH) ? 13'(MAX_WIDTH)
						: cfg.data[12:0];
				end
				REG_FRAME_HEIGHT: begin
					height_q <= (32'(cfg.data[12:0]) > MAX_HEIGHT) ? 13'(MAX_HEIGHT)
						: cfg.data[12:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign tcfg = '{exposure: exposure_q, curve_enable: curve_enable_q,
		curve_select: curve_select_q, gamma: gamma_q};

	assign en          = !vld_s[PIPE_DEPTH-1] || display.ready;
	assign accum.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < PIPE_DEPTH; k++) begin
				vld_s[k] <= 1'b0;
			end
		end else if (en) begin
			vld_s[0] <= accum.valid;
			for (int k = 1; k < PIPE_DEPTH; k++) begin
				vld_s[k] <= vld_s[k-1];
			end
		end
	end

	assign dy       = 24'(height_q) - 24'd1 - 24'(accum.row);
	assign idx_prod = dy * width_q;

	always_ff @(posedge clk) begin
		if (en) begin
			idx_s[0] <= 24'(idx_prod) + 24'(accum.column);
			for (int k = 1; k < PIPE_DEPTH; k++) begin
				idx_s[k] <= idx_s[k-1];
			end
		end
	end

	hdr_tm_chan u_red (
		.clk   (clk),
		.en    (en),
		.cfg   (tcfg),
		.sum   (accum.accum_red),
		.count (accum.sample_count),
		.pix   (display.out_red)
	);

	hdr_tm_chan u_green (
		.clk   (clk),
		.en    (en),
		.cfg   (tcfg),
		.sum   (accum.accum_green),
		.count (accum.sample_count),
		.pix   (display.out_green)
	);

	hdr_tm_chan u_blue (
		.clk   (clk),
		.en    (en),
		.cfg   (tcfg),
		.sum   (accum.accum_blue),
		.count (accum.sample_count),
		.pix   (display.out_blue)
	);

	assign display.valid       = vld_s[PIPE_DEPTH-1];
	assign display.pixel_index = idx_s[PIPE_DEPTH-1];

endmodule

// File: sim/hdr_tm_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// HDR tone mapper checker
// Watches the pixel, display and register channels, computes the expected
// display pixel for every accepted input and compares results in order.
// ---------------------------------------------------------------------------
module hdr_tm_checker
	import hdr_tm_pkg::*;
#(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
	input  logic  clk,
	input  logic  arst_n,
	hdr_tm_accum_if accum,
	hdr_tm_disp_if  display,
	hdr_tm_cfg_if   cfg,
	output int    fail_count,
	output int    pending,
	output int    result_count
);

	typedef struct packed {
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [23:0] index;
	} disp_pix_t;

	logic [31:0] exp_gain;
	logic        tone_on;
	logic [1:0]  tone_sel;
	logic [15:0] gamma_q8;
	logic [12:0] width_px;
	logic [12:0] height_px;

	disp_pix_t pixel_queue[$];

	function automatic logic [63:0] clamp_one(logic [63:0] v);
		return (v > 64'd65536) ? 64'd65536 : v;
	endfunction

	function automatic logic [63:0] apply_gamma(logic [63:0] v, logic [31:0] g);
		int          lead;
		logic [63:0] m, frac, nl, e, ei, ef, x, acc;
		logic [63:0] coef[6];
		coef = '{64'd10, 64'd87, 64'd630, 64'd3638, 64'd15743, 64'd45426};
		frac = 0;
		lead = 0;
		if (v == 0) begin
			return 0;
		end
		if (g == 0) begin
			g = 1;
		end
		for (int i = 0; i <= 16; i++) begin
			if (v[i]) begin
				lead = i;
			end
		end
		m = (v << 16) >> lead;
		for (int i = 0; i < 16; i++) begin
			m = (m * m) >> 16;
			frac = frac << 1;
			if (m >= 64'd131072) begin
				m = m >> 1;
				frac = frac | 1;
			end
		end
		nl = (64'(16 - lead) << 16) - frac;
		e = (nl * 256) / g;
		ei = e >> 16;
		ef = e & 64'hFFFF;
		if (ei >= 18) begin
			return 0;
		end
		if (ef == 0) begin
			return 64'd65536 >> ei;
		end
		x = 64'd65536 - ef;
		acc = coef[0];
		for (int i = 1; i < 6; i++) begin
			acc = coef[i] + ((acc * x) >> 16);
		end
		acc = 64'd65536 + ((acc * x) >> 16);
		return clamp_one(acc >> (ei + 1));
	endfunction

	function automatic logic [7:0] map_channel(logic [31:0] sum, logic [23:0] count);
		logic [63:0] x, y, xc, t1, t2, num, den, q;
		x = sum;
		if (count > 1) begin
			x = x / count;
		end
		x = (x * exp_gain) >> 16;
		if (x > 64'hFFFF_FFFF) begin
			x = 64'hFFFF_FFFF;
		end
		if (tone_on) begin
			if (tone_sel == CURVE_ACES) begin
				xc = (x > (64'd256 << 16)) ? (64'd256 << 16) : x;
				t1 = ((64'd164495 * xc) >> 16) + 1966;
				num = (xc * t1) >> 16;
				t2 = ((64'd159252 * xc) >> 16) + 38666;
				den = ((xc * t2) >> 16) + 9175;
				y = (num << 16) / den;
			end else if (tone_sel == CURVE_FILMIC) begin
				t1 = ((64'd9830 * x) >> 16) + 3277;
				num = ((x * t1) >> 16) + 262;
				t2 = ((64'd9830 * x) >> 16) + 32768;
				den = ((x * t2) >> 16) + 3932;
				q = (num << 16) / den;
				y = (q > 4369) ? q - 4369 : 0;
			end else begin
				y = (x << 16) / (x + 64'd65536);
			end
			y = apply_gamma(clamp_one(y), gamma_q8);
		end else begin
			y = clamp_one(x);
		end
		return 8'((y * 255) >> 16);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic [31:0] dy;
		disp_pix_t   p, want;
		if (!arst_n) begin
			exp_gain   <= 32'd65536;
			tone_on    <= 1'b1;
			tone_sel   <= CURVE_REINHARD;
			gamma_q8   <= 16'd563;
			width_px   <= 13'd1024;
			height_px  <= 13'd768;
			fail_count <= 0;
			result_count <= 0;
			pixel_queue.delete();
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					REG_EXPOSURE: exp_gain <= cfg.data;
					REG_CURVE_ENABLE: tone_on <= cfg.data[0];
					REG_CURVE_SELECT: tone_sel <= cfg.data[1:0];
					REG_GAMMA: gamma_q8 <= cfg.data[15:0];
					REG_FRAME_WIDTH: width_px <= (cfg.data[12:0] > MAX_WIDTH) ?
						13'(MAX_WIDTH) : cfg.data[12:0];
					REG_FRAME_HEIGHT: height_px <= (cfg.data[12:0] > MAX_HEIGHT) ?
						13'(MAX_HEIGHT) : cfg.data[12:0];
					default: ;
				endcase
			end
			if (accum.valid && accum.ready) begin
				dy = 32'(height_px) - 1 - 32'(accum.row);
				p.red   = map_channel(accum.accum_red, accum.sample_count);
				p.green = map_channel(accum.accum_green, accum.sample_count);
				p.blue  = map_channel(accum.accum_blue, accum.sample_count);
				p.index = 24'(dy * 32'(width_px) + 32'(accum.column));
				pixel_queue.push_back(p);
			end
			if (display.valid && display.ready) begin
				result_count <= result_count + 1;
				if (pixel_queue.size() == 0) begin
					$error("display transfer with no pixel expected");
					fail_count <= fail_count + 1;
				end else begin
					want = pixel_queue.pop_front();
					if (display.out_red !== want.red || display.out_green !== want.green ||
							display.out_blue !== want.blue ||
							display.pixel_index !== want.index) begin
						fail_count <= fail_count + 1;
						if (display.out_red !== want.red)
							$error("out_red expected %0d got %0d", want.red, display.out_red);
						if (display.out_green !== want.green)
							$error("out_green expected %0d got %0d", want.green,
								display.out_green);
						if (display.out_blue !== want.blue)
							$error("out_blue expected %0d got %0d", want.blue, display.out_blue);
						if (display.pixel_index !== want.index)
							$error("pixel_index expected %0d got %0d", want.index,
								display.pixel_index);
					end
				end
			end
		end
	end

	assign pending = pixel_queue.size();

endmodule

// File: sim/tb_hdr_tonemap_pixel.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// HDR tone mapper testbench
// Drives directed and random accumulated pixels through several register
// settings with random idling and back-pressure; the checker compares results.
// ---------------------------------------------------------------------------
module tb_hdr_tonemap_pixel;
	import hdr_tm_pkg::*;

	localparam int PIPE_LAT  = 110;
	localparam int WDOG_MAX  = 5000;
	localparam logic [2:0] REG_UNUSED = 3'd7;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   fail_count, pending, result_count;
	int   stall_cycles = 0;
	int   idle_cycles = 0;
	bit   calm = 1'b0;
	int   sent = 0;

	hdr_tm_accum_if accum ();
	hdr_tm_disp_if  display ();
	hdr_tm_cfg_if   cfg ();

	hdr_tonemap_pixel dut (.clk(clk), .arst_n(arst_n), .accum(accum), .display(display),
		.cfg(cfg));

	hdr_tm_checker chk (.clk(clk), .arst_n(arst_n), .accum(accum), .display(display),
		.cfg(cfg), .fail_count(fail_count), .pending(pending), .result_count(result_count));

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Receiver: random stalls, a calm stretch, and one long hold-off on request.
	initial begin
		display.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_cycles > 0) begin
				display.ready <= 1'b0;
				stall_cycles--;
			end else begin
				display.ready <= calm ? 1'b1 : ($urandom_range(99) >= 25);
			end
		end
	end

	always @(posedge clk) begin
		if ((accum.valid && accum.ready) || (display.valid && display.ready) || !arst_n) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WDOG_MAX) begin
				$display("watchdog expired after %0d idle cycles", idle_cycles);
				$display("** hdr_tonemap_pixel: FAILED **");
				$finish;
			end
		end
	end

	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= val;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		@(negedge clk);
		cfg.valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic drain_pipe();
		while (pending > 0) @(negedge clk);
		repeat (PIPE_LAT + 10) @(negedge clk);
	endtask

	task automatic send_pixel(logic [31:0] r, logic [31:0] g, logic [31:0] b,
			logic [23:0] cnt, logic [11:0] col, logic [11:0] rw);
		while (!calm && $urandom_range(99) < 25) begin
			accum.valid <= 1'b0;
			@(negedge clk);
		end
		accum.valid        <= 1'b1;
		accum.accum_red    <= r;
		accum.accum_green  <= g;
		accum.accum_blue   <= b;
		accum.sample_count <= cnt;
		accum.column       <= col;
		accum.row          <= rw;
		@(posedge clk);
		while (!accum.ready) @(posedge clk);
		sent++;
		@(negedge clk);
	endtask

	function automatic logic [31:0] rand_sum();
		case ($urandom_range(5))
			0: return $urandom;
			1: return $urandom_range(32'h0004_0000);
			2: return $urandom_range(32'h0000_2000);
			3: return 32'hFFFF_FFFF - $urandom_range(15);
			default: return $urandom_range(32'h0040_0000);
		endcase
	endfunction

	function automatic logic [23:0] rand_count();
		case ($urandom_range(4))
			0: return 24'($urandom_range(1));
			1: return 24'($urandom);
			default: return 24'($urandom_range(64));
		endcase
	endfunction

	task automatic random_pixels(int n);
		for (int i = 0; i < n; i++) begin
			send_pixel(rand_sum(), rand_sum(), rand_sum(), rand_count(),
				12'($urandom), 12'($urandom));
		end
		accum.valid <= 1'b0;
	endtask

	task automatic set_curve(logic [31:0] ex, logic en, logic [1:0] sel, logic [15:0] g,
			logic [12:0] w, logic [12:0] h);
		write_reg(REG_EXPOSURE, ex);
		write_reg(REG_CURVE_ENABLE, 32'(en));
		write_reg(REG_CURVE_SELECT, 32'(sel));
		write_reg(REG_GAMMA, 32'(g));
		write_reg(REG_FRAME_WIDTH, 32'(w));
		write_reg(REG_FRAME_HEIGHT, 32'(h));
	endtask

	initial begin
		accum.valid = 1'b0;
		accum.accum_red = '0;
		accum.accum_green = '0;
		accum.accum_blue = '0;
		accum.sample_count = '0;
		accum.column = '0;
		accum.row = '0;
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data = '0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed pixels at reset settings: field extremes and count edge cases.
		send_pixel(32'h0, 32'h0, 32'h0, 24'd0, 12'd0, 12'd0);
		send_pixel(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 24'd1, 12'd4095, 12'd4095);
		send_pixel(32'h0001_0000, 32'h0000_8000, 32'h0000_0001, 24'd2, 12'd1023, 12'd767);
		send_pixel(32'hFFFF_FFFF, 32'h1234_5678, 32'h0001_0000, 24'hFF_FFFF, 12'd5, 12'd9);
		send_pixel(32'h0000_FFFF, 32'h0002_0000, 32'h0100_0000, 24'd3, 12'd0, 12'd767);
		accum.valid <= 1'b0;
		drain_pipe();
		// Every curve, disabled curve, gamma zero and maximum, oversized frames.
		set_curve(32'h0001_0000, 1'b1, CURVE_ACES, 16'd0, 13'd8191, 13'd8191);
		send_pixel(32'h0007_4CCC, 32'hFFFF_FFFF, 32'h0000_0100, 24'd1, 12'd4095, 12'd0);
		send_pixel(32'h0100_0000, 32'h0000_4000, 32'h0003_0000, 24'd0, 12'd1, 12'd4095);
		accum.valid <= 1'b0;
		drain_pipe();
		set_curve(32'hFFFF_FFFF, 1'b1, CURVE_FILMIC, 16'hFFFF, 13'd0, 13'd0);
		send_pixel(32'h0, 32'h0000_0001, 32'h0000_0100, 24'd0, 12'd7, 12'd3);
		send_pixel(32'h0001_0000, 32'hFFFF_FFFF, 32'h0000_0010, 24'd1, 12'd4095, 12'd4095);
		accum.valid <= 1'b0;
		drain_pipe();
		set_curve(32'h0, 1'b0, CURVE_FALLBACK, 16'd1, 13'd1, 13'd1);
		send_pixel(32'hFFFF_FFFF, 32'h0001_0000, 32'h0, 24'd1, 12'd0, 12'd0);
		accum.valid <= 1'b0;
		drain_pipe();
		write_reg(REG_UNUSED, 32'hDEAD_BEEF);

		// Random phases across settings, with a long receiver hold-off in one.
		for (int ph = 0; ph < 6; ph++) begin
			set_curve($urandom_range(3) == 0 ? $urandom : $urandom_range(32'h0004_0000),
				1'($urandom_range(3) != 0), 2'(ph % 4), 16'($urandom_range(1, 1024)),
				13'($urandom_range(1, 4200)), 13'($urandom_range(1, 4200)));
			calm = (ph == 2);
			if (ph == 1) begin
				stall_cycles = 300;
			end
			random_pixels(250);
			drain_pipe();
		end
		calm = 1'b0;

		$display("Sent %0d pixels and checked %0d results over all curves and gain extremes.",
			sent, result_count);
		if (fail_count == 0) begin
			$display("** hdr_tonemap_pixel: PASSED **");
		end else begin
			$display("** hdr_tonemap_pixel: FAILED **");
		end
		$finish;
	end

endmodule

// File: sim.f
rtl/hdr_tm_pkg.sv
rtl/hdr_tm_intf.sv
rtl/hdr_tm_chan.sv
rtl/hdr_tonemap_pixel.sv
sim/hdr_tm_checker.sv
sim/tb_hdr_tonemap_pixel.sv
